// ===== sv/scba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Size-class block allocator package
// Shared sizes, operation and status codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package scba_pkg;

    localparam int NUM_CLASSES      = 4;
    localparam int BLOCKS_PER_CLASS = 256;
    localparam int TOTAL_BLOCKS     = NUM_CLASSES * BLOCKS_PER_CLASS;

    // Four class size registers; classes past the last one reuse it.
    localparam int NUM_CFG   = 4;
    localparam int CFG_IDX_W = 2;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 16;
    // Global 1-based block index and free totals.
    localparam int IDX_W    = $clog2(TOTAL_BLOCKS + 1);
    // Local index, end mark, watermark and per-class count.
    localparam int LOC_W    = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int ADDR_W   = $clog2(TOTAL_BLOCKS);
    localparam int CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd2;

    localparam logic [SIZE_W-1:0] CLASS_SIZE_RESET [NUM_CFG] =
        '{16'd64, 16'd128, 16'd256, 16'd512};

    typedef struct packed {
        logic load;         // capture the accepted request
        logic read_link;    // read the head block's link from the RAM
        logic commit_exec;  // finish a request that needs no link read
        logic commit_link;  // finish an allocate with the link just read
    } t_dp_cmd;

    typedef struct packed {
        logic need_link;    // allocate pops a block below the watermark
        logic slot_free;    // the result register can take a new result
    } t_dp_status;

endpackage
`default_nettype wire

// ===== sv/scba_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/scba_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences one request at a time: capture, execute, and an optional
// link read for allocates that pop a previously freed block.
// ----------------------------------------------------------------------------
module scba_ctrl import scba_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_sts,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LINK = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.need_link) begin
                    o_cmd.read_link = 1'b1;
                    n_state         = S_LINK;
                end else if (i_sts.slot_free) begin
                    o_cmd.commit_exec = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_LINK: begin
                if (i_sts.slot_free) begin
                    o_cmd.commit_link = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // The link state is reached right after a link read was issued and is
    // then held while the result register is still occupied.
    a_link_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> ($past(o_cmd.read_link) || $past(r_state == S_LINK)))
        else $error("link state entered without a link read");

    // A captured request always enters the execute state in the following cycle.
    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("captured request not executed");

endmodule
`default_nettype wire

// ===== sv/scba_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator datapath
// Class size registers, per-class list heads, watermarks and counts, the
// link RAM, the class search and the result register.
// ----------------------------------------------------------------------------
module scba_dp import scba_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_status                o_sts,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [SIZE_W-1:0]    i_need_size,
    input  wire logic [IDX_W-1:0]     i_free_index,
    input  wire logic                 i_cfg_write,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SIZE_W-1:0]    i_cfg_data,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic      [STATUS_W-1:0]  o_status,
    output logic      [IDX_W-1:0]     o_block_index,
    output logic      [SIZE_W-1:0]    o_granted_size,
    output logic      [IDX_W-1:0]     o_free_total
);

    // Captured request.
    logic [OP_W-1:0]   r_op;
    logic [SIZE_W-1:0] r_need;
    logic [IDX_W-1:0]  r_idx;

    logic [SIZE_W-1:0] r_class_size [NUM_CFG];
    logic [LOC_W-1:0]  r_head  [NUM_CLASSES];
    logic [LOC_W-1:0]  r_fresh [NUM_CLASSES];
    logic [LOC_W-1:0]  r_count [NUM_CLASSES];
    logic [IDX_W-1:0]  r_total;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_bidx;
    logic [SIZE_W-1:0]   r_gsize;

    logic [SIZE_W-1:0]   w_size [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] w_has;
    logic                w_found;
    logic [CLS_W-1:0]    w_sel;
    logic [LOC_W-1:0]    w_sel_head;
    logic                w_fresh;
    logic [IDX_W-1:0]    w_base;
    logic [IDX_W-1:0]    w_bidx;
    logic [ADDR_W-1:0]   w_raddr;
    logic                w_range_bad;
    logic [IDX_W-1:0]    w_g;
    logic [CLS_W-1:0]    w_fcls;
    logic [LOC_W-1:0]    w_floc;
    logic [LOC_W-1:0]    w_link;
    logic [LOC_W-1:0]    w_nxt;
    logic                w_commit;
    logic                w_link_we;
    logic [STATUS_W-1:0] w_res_status;
    logic [IDX_W-1:0]    w_res_bidx;
    logic [SIZE_W-1:0]   w_res_gsize;
    logic [IDX_W-1:0]    w_count_sum;

    // Class sizes, availability and the total used by the checks below.
    always_comb begin
        w_count_sum = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            w_size[c]   = r_class_size[(c < NUM_CFG) ? c : NUM_CFG - 1];
            w_has[c]    = (r_count[c] != '0) &&
                          (r_head[c] < LOC_W'(BLOCKS_PER_CLASS));
            w_count_sum = w_count_sum + IDX_W'(r_count[c]);
        end
    end

    // Upward search for a large enough class, then downward over the
    // smaller classes.
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (!w_found && (w_size[c] >= r_need) && w_has[c]) begin
                w_found = 1'b1;
                w_sel   = CLS_W'(c);
            end
        end
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (!w_found && (w_size[c] < r_need) && w_has[c]) begin
                w_found = 1'b1;
                w_sel   = CLS_W'(c);
            end
        end
    end

    assign w_sel_head = r_head[w_sel];
    assign w_fresh    = (w_sel_head >= r_fresh[w_sel]);
    assign w_base     = IDX_W'(w_sel) * IDX_W'(BLOCKS_PER_CLASS);
    assign w_bidx     = w_base + IDX_W'(w_sel_head) + IDX_W'(1);
    assign w_raddr    = ADDR_W'(w_base + IDX_W'(w_sel_head));

    // Free index decode: range check, then class by comparison with the
    // class base addresses.
    assign w_range_bad = (r_idx == '0) || (r_idx > IDX_W'(TOTAL_BLOCKS));
    assign w_g         = r_idx - IDX_W'(1);

    always_comb begin
        w_fcls = '0;
        for (int c = 1; c < NUM_CLASSES; c++) begin
            if (w_g >= IDX_W'(c * BLOCKS_PER_CLASS)) begin
                w_fcls = CLS_W'(c);
            end
        end
    end

    assign w_floc = LOC_W'(w_g - IDX_W'(w_fcls) * IDX_W'(BLOCKS_PER_CLASS));

    // A link never points past the end mark.
    assign w_nxt = (w_link > LOC_W'(BLOCKS_PER_CLASS)) ?
                   LOC_W'(BLOCKS_PER_CLASS) : w_link;

    assign w_link_we = i_cmd.commit_exec && (r_op == OP_FREE) && !w_range_bad;

    scba_ram #(
        .WIDTH (LOC_W),
        .DEPTH (TOTAL_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (ADDR_W'(w_g)),
        .i_wdata (r_head[w_fcls]),
        .i_re    (i_cmd.read_link),
        .i_raddr (w_raddr),
        .o_rdata (w_link)
    );

    assign o_sts.need_link = (r_op == OP_ALLOC) && w_found && !w_fresh;
    assign o_sts.slot_free = !r_out_valid || !i_out_stall;

    assign w_commit = i_cmd.commit_exec || i_cmd.commit_link;

    always_comb begin
        w_res_status = STAT_OK;
        w_res_bidx   = '0;
        w_res_gsize  = '0;
        case (r_op)
            OP_ALLOC: begin
                if (w_found) begin
                    w_res_bidx  = w_bidx;
                    w_res_gsize = w_size[w_sel];
                end else begin
                    w_res_status = STAT_NOFREE;
                end
            end
            OP_FREE: begin
                if (w_range_bad) begin
                    w_res_status = STAT_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and list state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CFG; c++) begin
                r_class_size[c] <= CLASS_SIZE_RESET[c];
            end
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_fresh[c] <= '0;
                r_count[c] <= LOC_W'(BLOCKS_PER_CLASS);
            end
            r_total     <= IDX_W'(TOTAL_BLOCKS);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_class_size[i_cfg_index] <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end
            if (i_cmd.commit_exec) begin
                case (r_op)
                    OP_ALLOC: begin
                        if (w_found) begin
                            r_head[w_sel]  <= w_sel_head + LOC_W'(1);
                            r_fresh[w_sel] <= w_sel_head + LOC_W'(1);
                            r_count[w_sel] <= r_count[w_sel] - LOC_W'(1);
                            r_total        <= r_total - IDX_W'(1);
                        end
                    end
                    OP_FREE: begin
                        if (!w_range_bad) begin
                            r_head[w_fcls] <= w_floc;
                            if (r_count[w_fcls] < LOC_W'(BLOCKS_PER_CLASS)) begin
                                r_count[w_fcls] <= r_count[w_fcls] + LOC_W'(1);
                                r_total         <= r_total + IDX_W'(1);
                            end
                        end
                    end
                    OP_REBUILD: begin
                        for (int c = 0; c < NUM_CLASSES; c++) begin
                            r_head[c]  <= '0;
                            r_fresh[c] <= '0;
                            r_count[c] <= LOC_W'(BLOCKS_PER_CLASS);
                        end
                        r_total <= IDX_W'(TOTAL_BLOCKS);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit_link) begin
                r_head[w_sel]  <= w_nxt;
                r_count[w_sel] <= r_count[w_sel] - LOC_W'(1);
                r_total        <= r_total - IDX_W'(1);
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_need <= i_need_size;
            r_idx  <= i_free_index;
        end
        if (w_commit) begin
            r_status <= w_res_status;
            r_bidx   <= w_res_bidx;
            r_gsize  <= w_res_gsize;
        end
    end

    // The running total only changes at a commit, which also replaces the
    // result, so it serves as the result's free total.
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_block_index  = r_bidx;
    assign o_granted_size = r_gsize;
    assign o_free_total   = r_total;

    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == w_count_sum)
        else $error("running free total differs from the class counts");

    a_commit_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> o_sts.slot_free)
        else $error("result committed over an unread result");

    a_link_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_link |-> ((r_op == OP_ALLOC) && w_found))
        else $error("link commit for a request that is not a granted allocate");

endmodule
`default_nettype wire

// ===== sv/size_class_block_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Size-class block allocator core
// Segregated free lists of equal blocks, one list per size class, with
// allocate, free by index and rebuild requests.
// ----------------------------------------------------------------------------
// The allocator handles one request at a time and produces one result per
// request. A free, a rebuild, a failed allocate and an allocate that takes a
// block at or above its class watermark finish after capture and execute;
// an allocate that pops a previously freed block adds a link read, since its
// next link comes out of the link RAM with registered read data. A new
// request is taken in the cycle after the previous one finishes, while its
// result may still sit in the result register; a request finishes only once
// that register is free, so a stalled output holds the request in flight.
// The link RAM is not initialized: links are written by free and read only
// for blocks below the watermark, so no clearing pass is needed and the block
// is ready directly after reset. Class size registers may be written only
// while no request is in flight; the write port is always ready.
// ----------------------------------------------------------------------------
module size_class_block_allocator_core import scba_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Request channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [SIZE_W-1:0]    i_need_size,
    input  wire logic [IDX_W-1:0]     i_free_index,

    // Result channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [STATUS_W-1:0]  o_status,
    output logic      [IDX_W-1:0]     o_block_index,
    output logic      [SIZE_W-1:0]    o_granted_size,
    output logic      [IDX_W-1:0]     o_free_total,

    // Class size register writes.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SIZE_W-1:0]    i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    assign o_cfg_ready = 1'b1;

    // The controller walks each request through capture, execute and the
    // optional link read; it only sees the datapath's status bundle.
    scba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds all list state, the link RAM and the result
    // register.
    scba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_operation    (i_operation),
        .i_need_size    (i_need_size),
        .i_free_index   (i_free_index),
        .i_cfg_write    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_block_index  (o_block_index),
        .o_granted_size (o_granted_size),
        .o_free_total   (o_free_total)
    );

endmodule
`default_nettype wire
